/* hdl/rptu_pkg.sv */
// shared types, character codes and helpers for the radix-prefixed text to unsigned converter
`timescale 1ns / 1ps
`default_nettype none
package rptu_pkg;

    localparam int VALUE_BITS = 32;
    localparam int SUM_BITS   = VALUE_BITS + 4;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_B    = 8'h42;
    localparam logic [7:0] CH_UP_H    = 8'h48;
    localparam logic [7:0] CH_UP_O    = 8'h4f;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_UP_Z    = 8'h5a;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_B    = 8'h62;
    localparam logic [7:0] CH_LO_H    = 8'h68;
    localparam logic [7:0] CH_LO_O    = 8'h6f;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_LO_Z    = 8'h7a;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    typedef enum logic [1:0] {
        RC_DEC = 2'd0,
        RC_HEX = 2'd1,
        RC_OCT = 2'd2,
        RC_BIN = 2'd3
    } t_radix;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last_char;
    } t_in_req;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  overflowed;
    } t_out_req;

    function automatic logic [4:0] radix_value(t_radix rc);
        logic [4:0] r;
        case (rc)
            RC_DEC:  r = 5'd10;
            RC_HEX:  r = 5'd16;
            RC_OCT:  r = 5'd8;
            RC_BIN:  r = 5'd2;
            default: r = 5'd10;
        endcase
        return r;
    endfunction

    // digit value of a byte (letters count from 10), 63 when it is neither a decimal digit nor a letter
    function automatic logic [5:0] digit_of(logic [7:0] c);
        logic [5:0] d;
        d = 6'd63;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 6'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = 6'(c - CH_LO_A + LETTER_OFS);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = 6'(c - CH_UP_A + LETTER_OFS);
        end
        return d;
    endfunction

endpackage
`default_nettype wire

/* hdl/rptu_digit.sv */
// one digit step: decode, multiply by radix, add, saturate
`timescale 1ns / 1ps
`default_nettype none
module rptu_digit (
    input  logic [rptu_pkg::VALUE_BITS-1:0] i_acc,
    input  logic                            i_sat,
    input  rptu_pkg::t_radix                i_radix,
    input  logic [7:0]                      i_char,
    output logic                            o_ok,
    output logic [rptu_pkg::VALUE_BITS-1:0] o_acc,
    output logic                            o_sat
);
    import rptu_pkg::*;

    logic [5:0]          w_dig;
    logic [4:0]          w_rad;
    logic [SUM_BITS-1:0] w_scaled;
    logic [SUM_BITS-1:0] w_sum;
    logic                w_ovf;

    assign w_dig = digit_of(i_char);
    assign w_rad = radix_value(i_radix);
    assign o_ok  = (w_dig < {1'b0, w_rad});

    always_comb begin
        case (i_radix)
            RC_HEX:  w_scaled = {i_acc, 4'b0000};
            RC_OCT:  w_scaled = {1'b0, i_acc, 3'b000};
            RC_BIN:  w_scaled = {3'b000, i_acc, 1'b0};
            RC_DEC:  w_scaled = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0};
            default: w_scaled = {4'b0000, i_acc};
        endcase
    end

    assign w_sum = w_scaled + SUM_BITS'(w_dig[3:0]);
    assign w_ovf = |w_sum[SUM_BITS-1:VALUE_BITS];
    assign o_sat = i_sat | w_ovf;
    assign o_acc = (i_sat || w_ovf) ? {VALUE_BITS{1'b1}} : w_sum[VALUE_BITS-1:0];

endmodule
`default_nettype wire

/* hdl/radix_prefixed_text_to_uint.sv */
// top level: radix-prefixed text to unsigned integer converter
// a last-character request loads the result register as it leaves the input register
// throughput: one character request per cycle, set by the single digit step
//   (shift-add by radix, add, overflow check) between input and state registers
// a result waiting in the output register stalls only a last-character request
// synchronous active-low reset empties both registers and returns to leading-space skip
`timescale 1ns / 1ps
`default_nettype none
module radix_prefixed_text_to_uint (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rptu_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rptu_pkg::t_out_req o_out_data
);
    import rptu_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_AMP,
        PH_WS,
        PH_SIGNED,
        PH_PREFIXED,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    logic                  r_in_valid;
    t_in_req               r_in;
    logic                  r_out_valid;
    t_out_req              r_out;
    t_phase                r_phase, n_phase, c_phase;
    t_radix                r_radix, n_radix, c_radix;
    logic [VALUE_BITS-1:0] r_acc, n_acc, c_acc;
    logic                  r_neg, n_neg, c_neg;
    logic                  r_sat, n_sat, c_sat;
    logic                  r_ozs, n_ozs, c_ozs;
    t_out_req              n_out;

    logic                  w_adv;
    logic [7:0]            w_ch;
    logic                  w_is_ws;
    logic                  w_ok;
    logic [VALUE_BITS-1:0] w_dacc;
    logic                  w_dsat;

    rptu_digit u_digit (
        .i_acc   (r_acc),
        .i_sat   (r_sat),
        .i_radix (r_radix),
        .i_char  (w_ch),
        .o_ok    (w_ok),
        .o_acc   (w_dacc),
        .o_sat   (w_dsat)
    );

    assign w_ch    = r_in.char_code;
    assign w_is_ws = (w_ch == CH_SPACE) || (w_ch >= CH_TAB && w_ch <= CH_CR);
    assign w_adv   = r_in_valid && (!r_in.last_char || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        c_phase = r_phase;
        c_radix = r_radix;
        c_acc   = r_acc;
        c_neg   = r_neg;
        c_sat   = r_sat;
        c_ozs   = r_ozs;
        if (r_in.has_char) begin
            case (r_phase)
                PH_LEAD, PH_WS: begin
                    if (r_phase == PH_LEAD && w_ch == CH_SPACE) begin
                        c_phase = PH_LEAD;
                    end else if (r_phase == PH_LEAD && w_ch == CH_AMP) begin
                        c_phase = PH_AMP;
                    end else begin
                        c_phase = PH_WS;
                        if (w_is_ws) begin
                            c_phase = PH_WS;
                        end else if (w_ch == CH_PLUS) begin
                            c_phase = PH_SIGNED;
                        end else if (w_ch == CH_MINUS) begin
                            c_neg   = 1'b1;
                            c_phase = PH_SIGNED;
                        end else if (r_radix == RC_HEX && w_ch == CH_ZERO) begin
                            c_ozs   = 1'b1;
                            c_phase = PH_DIGITS;
                        end else if (w_ok) begin
                            c_acc   = w_dacc;
                            c_sat   = w_dsat;
                            c_phase = PH_DIGITS;
                        end else begin
                            c_phase = PH_DONE;
                        end
                    end
                end
                PH_AMP: begin
                    c_phase = PH_WS;
                    if (w_ch == CH_LO_H || w_ch == CH_UP_H) begin
                        c_radix = RC_HEX;
                    end else if (w_ch == CH_LO_O || w_ch == CH_UP_O) begin
                        c_radix = RC_OCT;
                    end else if (w_ch == CH_LO_B || w_ch == CH_UP_B) begin
                        c_radix = RC_BIN;
                    end else begin
                        c_phase = PH_DONE;
                    end
                end
                PH_SIGNED: begin
                    if (r_radix == RC_HEX && w_ch == CH_ZERO) begin
                        c_ozs   = 1'b1;
                        c_phase = PH_DIGITS;
                    end else if (w_ok) begin
                        c_acc   = w_dacc;
                        c_sat   = w_dsat;
                        c_phase = PH_DIGITS;
                    end else begin
                        c_phase = PH_DONE;
                    end
                end
                PH_PREFIXED: begin
                    if (w_ok) begin
                        c_acc   = w_dacc;
                        c_sat   = w_dsat;
                        c_phase = PH_DIGITS;
                    end else begin
                        c_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    c_ozs = 1'b0;
                    if (r_ozs && (w_ch == CH_LO_X || w_ch == CH_UP_X)) begin
                        c_phase = PH_PREFIXED;
                    end else if (w_ok) begin
                        c_acc = w_dacc;
                        c_sat = w_dsat;
                    end else begin
                        c_phase = PH_DONE;
                    end
                end
                default: begin
                    c_phase = PH_DONE;
                end
            endcase
        end

        n_out.overflowed = c_sat;
        if (c_sat) begin
            n_out.value = {VALUE_BITS{1'b1}};
        end else if (c_neg) begin
            n_out.value = ~c_acc + VALUE_BITS'(1);
        end else begin
            n_out.value = c_acc;
        end

        // a last character closes the string and restarts the scan
        if (r_in.last_char) begin
            n_phase = PH_LEAD;
            n_radix = RC_DEC;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_sat   = 1'b0;
            n_ozs   = 1'b0;
        end else begin
            n_phase = c_phase;
            n_radix = c_radix;
            n_acc   = c_acc;
            n_neg   = c_neg;
            n_sat   = c_sat;
            n_ozs   = c_ozs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LEAD;
            r_radix     <= RC_DEC;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_sat       <= 1'b0;
            r_ozs       <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (o_in_ready && i_in_valid) begin
                r_in <= i_in_data;
            end
            if (w_adv) begin
                r_phase <= n_phase;
                r_radix <= n_radix;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_sat   <= n_sat;
                r_ozs   <= n_ozs;
            end
            if (w_adv && r_in.last_char) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.last_char) |=> r_out_valid)
        else $error("last character request did not produce a result");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.last_char) |=> (r_phase == PH_LEAD && r_acc == '0 && !r_sat))
        else $error("state not cleared after end of string");

    a_sat_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (&r_acc))
        else $error("saturated accumulator is not all ones");

    a_ovf_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.overflowed) |-> (&r_out.value))
        else $error("overflowed result is not all ones");

endmodule
`default_nettype wire

/* sim/radix_prefixed_text_to_uint_tb.sv */
// testbench for the radix-prefixed text to unsigned converter: queued text, own scanner, checks
`timescale 1ns / 1ps
module radix_prefixed_text_to_uint_tb;
    import rptu_pkg::*;

    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_AMP,
        SCAN_WS,
        SCAN_SIGNED,
        SCAN_PREFIXED,
        SCAN_DIGITS,
        SCAN_DONE
    } t_scan;

    logic     i_clk;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    logic     out_ready = 1'b0;
    t_in_req  in_data   = '0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_out_req o_out_data;

    t_in_req  pending_requests[$];
    t_out_req expected_results[$];
    int       in_queued    = 0;
    int       in_sent      = 0;
    int       results_seen = 0;
    int       errors       = 0;
    bit       in_taken     = 1'b0;
    int       hold_left    = 0;
    bit       hold_done    = 1'b0;

    t_scan                 scan_phase;
    t_radix                scan_radix;
    logic [VALUE_BITS-1:0] scan_acc;
    bit                    scan_neg;
    bit                    scan_sat;
    bit                    scan_lone_zero;

    radix_prefixed_text_to_uint dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(12 * 200000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void clear_scan();
        scan_phase     = SCAN_LEAD;
        scan_radix     = RC_DEC;
        scan_acc       = '0;
        scan_neg       = 1'b0;
        scan_sat       = 1'b0;
        scan_lone_zero = 1'b0;
    endfunction

    function automatic logic [5:0] char_digit(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return 6'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            return 6'(c - CH_LO_A) + 6'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return 6'(c - CH_UP_A) + 6'd10;
        end
        return 6'd63;
    endfunction

    function automatic logic [5:0] base_of(t_radix rc);
        case (rc)
            RC_HEX:  return 6'd16;
            RC_OCT:  return 6'd8;
            RC_BIN:  return 6'd2;
            default: return 6'd10;
        endcase
    endfunction

    function automatic bit add_digit(logic [7:0] c);
        logic [5:0]       d;
        longint unsigned  next_val;
        d = char_digit(c);
        if (d >= base_of(scan_radix)) return 1'b0;
        if (!scan_sat) begin
            next_val = 64'(scan_acc) * 64'(base_of(scan_radix)) + 64'(d);
            if (next_val > VALUE_MAX) begin
                scan_sat = 1'b1;
                scan_acc = '1;
            end else begin
                scan_acc = next_val[VALUE_BITS-1:0];
            end
        end
        return 1'b1;
    endfunction

    function automatic void start_number(logic [7:0] c);
        if (scan_radix == RC_HEX && c == CH_ZERO) begin
            scan_lone_zero = 1'b1;
            scan_phase     = SCAN_DIGITS;
        end else if (add_digit(c)) begin
            scan_phase = SCAN_DIGITS;
        end else begin
            scan_phase = SCAN_DONE;
        end
    endfunction

    function automatic void scan_char(logic [7:0] c);
        if (scan_phase == SCAN_LEAD) begin
            if (c == CH_SPACE) return;
            if (c == CH_AMP) begin
                scan_phase = SCAN_AMP;
                return;
            end
            scan_phase = SCAN_WS;
        end
        case (scan_phase)
            SCAN_WS: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
                if (c == CH_PLUS) begin
                    scan_phase = SCAN_SIGNED;
                end else if (c == CH_MINUS) begin
                    scan_neg   = 1'b1;
                    scan_phase = SCAN_SIGNED;
                end else begin
                    start_number(c);
                end
            end
            SCAN_AMP: begin
                if (c == CH_LO_H || c == CH_UP_H) begin
                    scan_radix = RC_HEX;
                    scan_phase = SCAN_WS;
                end else if (c == CH_LO_O || c == CH_UP_O) begin
                    scan_radix = RC_OCT;
                    scan_phase = SCAN_WS;
                end else if (c == CH_LO_B || c == CH_UP_B) begin
                    scan_radix = RC_BIN;
                    scan_phase = SCAN_WS;
                end else begin
                    scan_phase = SCAN_DONE;
                end
            end
            SCAN_SIGNED: start_number(c);
            SCAN_PREFIXED: scan_phase = add_digit(c) ? SCAN_DIGITS : SCAN_DONE;
            SCAN_DIGITS: begin
                if (scan_lone_zero && (c == CH_LO_X || c == CH_UP_X)) begin
                    scan_lone_zero = 1'b0;
                    scan_phase     = SCAN_PREFIXED;
                end else begin
                    scan_lone_zero = 1'b0;
                    if (!add_digit(c)) scan_phase = SCAN_DONE;
                end
            end
            default: scan_phase = SCAN_DONE;
        endcase
    endfunction

    function automatic void predict_request(t_in_req r);
        t_out_req res;
        if (r.has_char) scan_char(r.char_code);
        if (r.last_char) begin
            res.value      = scan_sat ? '1 : (scan_neg ? -scan_acc : scan_acc);
            res.overflowed = scan_sat;
            expected_results.push_back(res);
            clear_scan();
        end
    endfunction

    task automatic queue_bytes(input logic [7:0] txt[$], input bit sprinkle);
        t_in_req r;
        bit      split_end;
        split_end = sprinkle && ($urandom_range(9) == 0);
        foreach (txt[i]) begin
            if (sprinkle && $urandom_range(99) < 5) begin
                r = '{char_code: 8'($urandom_range(255)), has_char: 1'b0, last_char: 1'b0};
                pending_requests.push_back(r);
                in_queued++;
            end
            r.char_code = txt[i];
            r.has_char  = 1'b1;
            r.last_char = (i == txt.size() - 1) && !split_end;
            pending_requests.push_back(r);
            in_queued++;
        end
        if (txt.size() == 0 || split_end) begin
            r = '{char_code: 8'($urandom_range(255)), has_char: 1'b0, last_char: 1'b1};
            pending_requests.push_back(r);
            in_queued++;
        end
    endtask

    task automatic queue_string(input string s);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        queue_bytes(txt, 1'b0);
    endtask

    // request side: prediction on accept, result side: compare with oldest expectation
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) clear_scan();
        in_taken = i_rst_n && in_valid && o_in_ready;
        if (in_taken) begin
            predict_request(in_data);
            in_sent++;
        end
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result: value %h overflowed %b",
                       o_out_data.value, o_out_data.overflowed);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, o_out_data.value);
                    errors++;
                end
                if (o_out_data.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %b, got %b",
                           want.overflowed, o_out_data.overflowed);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_requests.size() != 0 &&
                ((in_sent >= 250 && in_sent < 400) || $urandom_range(99) >= 25)) begin
                in_data  <= pending_requests.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // long hold-off so the request side backs up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (results_seen >= 40 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
            out_ready <= 1'b0;
        end else if (results_seen >= 55 && results_seen < 75) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 25);
        end
    end

    initial begin
        logic [7:0] txt[$];
        logic [7:0] tricky[0:11];
        int         directed_items;
        int         kind;
        int         rc;
        int         maxlen;
        int         d;

        tricky = '{CH_SPACE, CH_AMP, CH_PLUS, CH_MINUS, CH_ZERO, CH_LO_X, CH_UP_X,
                   CH_LO_H, CH_UP_B, CH_TAB, CH_CR, 8'h00};

        queue_string("");
        queue_string("0");
        queue_string("4294967295");
        queue_string("4294967296");
        queue_string("-1");
        queue_string("  &hFFFFFFFF");
        queue_string("&H100000000");
        queue_string("&O777");
        queue_string("&b101");
        queue_string("&B");
        queue_string("&");
        queue_string("&Z12");
        queue_string("&h \t-0x1f");
        queue_string("&H0xg");
        queue_string("&h0X");
        queue_string("\t+0x1A");
        queue_string("-99999999999");
        queue_string("- 5");
        queue_string(" \v\f\n7");
        queue_string("zz");
        queue_string("&o8");
        queue_string("1\xff9");
        txt = '{8'h31, 8'h32, 8'h00, 8'h34};
        queue_bytes(txt, 1'b0);
        directed_items = in_queued;

        // sender pause: let every directed result come back first
        while (in_sent != in_queued || expected_results.size() != 0) @(negedge i_clk);

        while (in_queued < directed_items + 480) begin
            txt.delete();
            kind = $urandom_range(99);
            if (kind < 5) begin
                // empty string
            end else if (kind < 20) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(1)) txt.push_back(8'($urandom_range(255)));
                    else txt.push_back(tricky[$urandom_range(11)]);
                end
            end else begin
                repeat ($urandom_range(0, 2)) txt.push_back(CH_SPACE);
                rc = $urandom_range(3);
                if (t_radix'(rc) != RC_DEC) begin
                    txt.push_back(CH_AMP);
                    case (t_radix'(rc))
                        RC_HEX:  txt.push_back($urandom_range(1) ? CH_LO_H : CH_UP_H);
                        RC_OCT:  txt.push_back($urandom_range(1) ? CH_LO_O : CH_UP_O);
                        default: txt.push_back($urandom_range(1) ? CH_LO_B : CH_UP_B);
                    endcase
                end
                if ($urandom_range(3) == 0) begin
                    txt.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)));
                end
                case ($urandom_range(5))
                    0: txt.push_back(CH_PLUS);
                    1: txt.push_back(CH_MINUS);
                    default: ;
                endcase
                if (t_radix'(rc) == RC_HEX && $urandom_range(2) == 0) begin
                    txt.push_back(CH_ZERO);
                    txt.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
                end
                case (t_radix'(rc))
                    RC_HEX:  maxlen = 10;
                    RC_OCT:  maxlen = 12;
                    RC_BIN:  maxlen = 34;
                    default: maxlen = 11;
                endcase
                repeat ($urandom_range(1, maxlen)) begin
                    d = $urandom_range(base_of(t_radix'(rc)) - 1);
                    if (d < 10) txt.push_back(CH_ZERO + 8'(d));
                    else txt.push_back(($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(d - 10));
                end
                if ($urandom_range(3) == 0) begin
                    txt.push_back(8'($urandom_range(255)));
                    if ($urandom_range(1)) txt.push_back(CH_ZERO + 8'($urandom_range(9)));
                end
                if ($urandom_range(9) == 0) txt[$urandom_range(txt.size() - 1)] =
                    8'($urandom_range(255));
            end
            queue_bytes(txt, 1'b1);
        end

        while (in_sent != in_queued || expected_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/rptu_pkg.sv
hdl/rptu_digit.sv
hdl/radix_prefixed_text_to_uint.sv
sim/radix_prefixed_text_to_uint_tb.sv
